// ----- src/quant_weight_bitplane_packer_assert.svh -----
// ----------------------------------------------------------------------------
// quant_weight_bitplane_packer assertion macros
// Concurrent checks clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef QUANT_WEIGHT_BITPLANE_PACKER_ASSERT_SVH
`define QUANT_WEIGHT_BITPLANE_PACKER_ASSERT_SVH

`ifndef ASSERT_OFF

// condition must hold at every edge
`define QWBP_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define QWBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define QWBP_ASSERT(label, cond, msg)
`define QWBP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- src/qwbp_pkg.sv -----
// ----------------------------------------------------------------------------
// qwbp_pkg
// Constants and bit interleaving functions of the weight bit plane packer.
// ----------------------------------------------------------------------------
package qwbp_pkg;

  localparam int GROUP_SIZE = 32;
  localparam int COUNT_W    = $clog2(GROUP_SIZE);

  localparam logic [COUNT_W-1:0] LAST_ELEMENT = COUNT_W'(GROUP_SIZE - 1);

  // bit width thresholds that enable the planes
  localparam logic [3:0] BW_RESET  = 4'd4;
  localparam logic [3:0] BW_PLANE1 = 4'd3;
  localparam logic [3:0] BW_PLANE2 = 4'd4;
  localparam logic [3:0] BW_PLANE3 = 4'd6;
  localparam logic [3:0] BW_PLANE4 = 4'd8;

  // 2-bit group k of the low half goes to 4k, of the high half to 4k+2
  function automatic logic [31:0] pack_pairs(input logic [31:0] w);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r[4*k +: 2]     = w[2*k +: 2];
      r[4*k + 2 +: 2] = w[16 + 2*k +: 2];
    end
    return r;
  endfunction

  // bit m of byte q goes to 4m+3-q
  function automatic logic [31:0] pack_bits(input logic [31:0] w);
    logic [31:0] r;
    r = '0;
    for (int q = 0; q < 4; q++) begin
      for (int m = 0; m < 8; m++) begin
        r[4*m + 3 - q] = w[8*q + m];
      end
    end
    return r;
  endfunction

endpackage

// ----- src/quant_weight_bitplane_packer.sv -----
// ----------------------------------------------------------------------------
// quant_weight_bitplane_packer
// Packs groups of 32 quantized weight bytes into interleaved bit planes.
// ----------------------------------------------------------------------------
// Throughput: one weight byte per cycle unless the 32nd byte stalls; one result
// of eight words per 32 bytes, valid in the cycle after the 32nd byte is taken.
// Bytes 1 to 31 of a group are taken even while a result waits; only the
// 32nd byte stalls until the result register is free.
// Reset clears the element count, accumulators and out_valid; bit_width is 4.
`include "quant_weight_bitplane_packer_assert.svh"

module quant_weight_bitplane_packer
  import qwbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  // weight byte stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  weight_byte,
  // packed planes
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] plane0_low,
  output logic [31:0] plane0_high,
  output logic [31:0] plane1_word,
  output logic [31:0] plane2_word,
  output logic [31:0] plane3_low,
  output logic [31:0] plane3_high,
  output logic [31:0] plane4_low,
  output logic [31:0] plane4_high
);

  logic [3:0]         bit_width;
  logic [COUNT_W-1:0] element_count;
  logic [63:0]        acc_plane0, acc_plane0_next;
  logic [31:0]        acc_plane1, acc_plane1_next;
  logic [31:0]        acc_plane2, acc_plane2_next;
  logic [63:0]        acc_plane3, acc_plane3_next;
  logic [63:0]        acc_plane4, acc_plane4_next;

  logic in_accept;
  logic group_done;
  logic en_plane1, en_plane2, en_plane3, en_plane4;

  assign cfg_ready = 1'b1;

  assign en_plane1 = (bit_width >= BW_PLANE1);
  assign en_plane2 = (bit_width >= BW_PLANE2);
  assign en_plane3 = (bit_width >= BW_PLANE3);
  assign en_plane4 = (bit_width >= BW_PLANE4);

  // only the closing byte of a group needs the result register
  assign in_stall   = out_valid && out_stall && (element_count == LAST_ELEMENT);
  assign in_accept  = in_valid && !in_stall;
  assign group_done = in_accept && (element_count == LAST_ELEMENT);

  // positions not yet written are still zero, so a plain write equals an or
  always_comb begin
    acc_plane0_next = acc_plane0;
    acc_plane1_next = acc_plane1;
    acc_plane2_next = acc_plane2;
    acc_plane3_next = acc_plane3;
    acc_plane4_next = acc_plane4;
    acc_plane0_next[{element_count, 1'b0} +: 2] = weight_byte[1:0];
    acc_plane1_next[element_count]              = weight_byte[2];
    acc_plane2_next[element_count]              = weight_byte[3] & en_plane2;
    acc_plane3_next[{element_count, 1'b0} +: 2] = weight_byte[5:4] & {2{en_plane3}};
    acc_plane4_next[{element_count, 1'b0} +: 2] = weight_byte[7:6] & {2{en_plane4}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_width <= BW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bit_width <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      acc_plane0    <= '0;
      acc_plane1    <= '0;
      acc_plane2    <= '0;
      acc_plane3    <= '0;
      acc_plane4    <= '0;
    end else if (group_done) begin
      element_count <= '0;
      acc_plane0    <= '0;
      acc_plane1    <= '0;
      acc_plane2    <= '0;
      acc_plane3    <= '0;
      acc_plane4    <= '0;
    end else if (in_accept) begin
      element_count <= element_count + 1'b1;
      acc_plane0    <= acc_plane0_next;
      acc_plane1    <= acc_plane1_next;
      acc_plane2    <= acc_plane2_next;
      acc_plane3    <= acc_plane3_next;
      acc_plane4    <= acc_plane4_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (group_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (group_done) begin
      plane0_low  <= pack_pairs(acc_plane0_next[31:0]);
      plane0_high <= pack_pairs(acc_plane0_next[63:32]);
      plane1_word <= en_plane1 ? pack_bits(acc_plane1_next) : '0;
      plane2_word <= en_plane2 ? pack_bits(acc_plane2_next) : '0;
      plane3_low  <= en_plane3 ? pack_pairs(acc_plane3_next[31:0]) : '0;
      plane3_high <= en_plane3 ? pack_pairs(acc_plane3_next[63:32]) : '0;
      plane4_low  <= en_plane4 ? pack_pairs(acc_plane4_next[31:0]) : '0;
      plane4_high <= en_plane4 ? pack_pairs(acc_plane4_next[63:32]) : '0;
    end
  end

  `QWBP_ASSERT(a_stall_only_on_full, !in_stall || (out_valid && element_count == LAST_ELEMENT), "input stalled without a pending result on the closing byte")
  `QWBP_ASSERT_NEXT(a_result_after_group, group_done, out_valid, "no result after the closing byte")
  `QWBP_ASSERT_NEXT(a_clear_after_group, group_done, element_count == '0 && acc_plane0 == '0 && acc_plane4 == '0, "group state not cleared after result")
  `QWBP_ASSERT_NEXT(a_count_advance, in_accept && !group_done, element_count == $past(element_count) + 1'b1, "element count did not advance")

endmodule
